### hw/rtl/lzwd_pkg.sv
// Shared types and constants for the variable-width LZW decoder.
// Used by lzwd_dict and lzw_decoder_variable_width; depends on nothing.
`default_nettype none

package lzwd_pkg;

   localparam int CODE_W   = 12;   // widest code and dictionary index
   localparam int DEPTH_W  = 13;   // stack depth and dictionary size
   localparam int COUNT_W  = 25;   // decoded byte counter
   localparam int BUF_W    = 19;   // bit buffer
   localparam int CNT_W    = 5;    // bits held in the buffer

   localparam logic [CODE_W-1:0]  CODE_CLEAR  = 12'h100;
   localparam logic [CODE_W-1:0]  CODE_STOP   = 12'h101;
   localparam logic [CODE_W-1:0]  CODE_FIRST  = 12'h102;
   localparam logic [DEPTH_W-1:0] DICT_FIRST  = 13'h0102;
   localparam logic [DEPTH_W-1:0] DICT_FULL   = 13'h1000;
   localparam logic [3:0]         START_WIDTH = 4'd9;
   localparam logic [3:0]         MAX_WIDTH   = 4'd12;

   localparam logic [2:0] ADDR_EXPECTED = 3'd0;

   // word kinds on the request channel
   localparam logic [1:0] KIND_START = 2'd0;
   localparam logic [1:0] KIND_BYTE  = 2'd1;
   localparam logic [1:0] KIND_END   = 2'd2;
   localparam logic [1:0] KIND_PULL  = 2'd3;

   // stream status codes
   localparam logic [2:0] STAT_RUNNING   = 3'd0;
   localparam logic [2:0] STAT_DONE      = 3'd1;
   localparam logic [2:0] STAT_MISMATCH  = 3'd2;
   localparam logic [2:0] STAT_BAD_CODE  = 3'd3;
   localparam logic [2:0] STAT_OVERFLOW  = 3'd4;
   localparam logic [2:0] STAT_TRUNCATED = 3'd5;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_WALK_RD,
      ST_WALK_WR,
      ST_FINISH,
      ST_POP,
      ST_RESP
   } seq_state_type;

   typedef struct packed {
      logic              en;
      logic [CODE_W-1:0] addr;
      logic [CODE_W-1:0] prefix;
      logic [7:0]        data;
   } dict_wr_type;

endpackage

`default_nettype wire

### hw/rtl/lzwd_dict.sv
// LZW dictionary store: prefix code and suffix byte per entry, one write
// and one registered read per cycle. Depends on lzwd_pkg.
`default_nettype none

module lzwd_dict (
   input  wire logic                       clock,
   input  wire lzwd_pkg::dict_wr_type      wr,
   input  wire logic                       rd_en,
   input  wire logic [lzwd_pkg::CODE_W-1:0] rd_addr,
   output logic      [lzwd_pkg::CODE_W-1:0] rd_prefix,
   output logic      [7:0]                  rd_data
);

   logic [lzwd_pkg::CODE_W-1:0] entry_prefix_mem [1 << lzwd_pkg::CODE_W];
   logic [7:0]                  entry_byte_mem   [1 << lzwd_pkg::CODE_W];

   // write a new entry
   always_ff @(posedge clock) begin
      if (wr.en) begin
         entry_prefix_mem[wr.addr] <= wr.prefix;
         entry_byte_mem[wr.addr]   <= wr.data;
      end
   end

   // registered read of one link
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_prefix <= entry_prefix_mem[rd_addr];
         rd_data   <= entry_byte_mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

### hw/rtl/lzw_decoder_variable_width.sv
// Top level of the streaming LZW decoder: request/response stream channels,
// APB-style register port, sequencer, bit unpacker and output stack.
// Depends on lzwd_pkg and lzwd_dict.
`default_nettype none

// Decodes an LZW stream of 9- to 12-bit codes packed LSB first. Each request
// word is one of: start a new stream, one compressed byte, end of source, or
// a pull of one decoded byte; each request gives exactly one response word
// with the flags, status and byte count. The block handles one word at a
// time: a word is accepted in the idle state and its response is then
// presented until taken; a pull from the stack first passes through the
// registered stack read. A byte that completes a clear, stop or bad code
// goes through the decode step before its response. A byte that completes a
// data code is decoded, then walks the dictionary links of the decoded
// string, one dictionary read and one stack write per link, and finishes
// before its response. Compressed bytes are refused (accepted flag low) while
// decoded output is still waiting to be pulled.
// Register expected_length lies at byte address 0.
module lzw_decoder_variable_width (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] byte_in
   input  wire logic [1:0]  req_tuser,   // [1:0] kind
   // response channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata,   // [7:0] out_byte, [10:8] status,
                                         // [35:11] written_count, rest zero
   output logic [2:0]       rsp_tuser,   // [0] accepted, [1] out_valid,
                                         // [2] need_input
   // register port
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   localparam int CW = lzwd_pkg::CODE_W;
   localparam int DW = lzwd_pkg::DEPTH_W;
   localparam int NW = lzwd_pkg::COUNT_W;
   localparam int BW = lzwd_pkg::BUF_W;
   localparam int KW = lzwd_pkg::CNT_W;

   lzwd_pkg::seq_state_type state_ff, state_in;

   logic [BW-1:0] bitbuf_ff, bitbuf_in;
   logic [KW-1:0] bitcnt_ff, bitcnt_in;
   logic [3:0]    width_ff, width_in;
   logic [DW-1:0] dict_size_ff, dict_size_in;
   logic [CW-1:0] prev_ff, prev_in;
   logic [7:0]    first_ff, first_in;
   logic [NW-1:0] count_ff, count_in;
   logic          repeat_ff, repeat_in;
   logic          phase_ff, phase_in;
   logic [2:0]    status_ff, status_in;
   logic [DW-1:0] depth_ff, depth_in;
   logic [NW-1:0] expected_ff, expected_in;
   logic [CW-1:0] code_ff, code_in;
   logic [CW-1:0] walk_c_ff, walk_c_in;
   logic [DW-1:0] wdepth_ff, wdepth_in;
   logic          special_ff, special_in;
   logic          acc_ff, acc_in;
   logic          valid_ff, valid_in;
   logic [7:0]    obyte_ff, obyte_in;

   // unpacker and decode helpers
   logic [BW-1:0] merged;
   logic [KW-1:0] cnt_sum;
   logic [CW-1:0] code_mask;
   logic          running;
   logic          special;
   logic [CW-1:0] chain_start;
   logic          adding;
   logic [NW-1:0] str_len;
   logic [NW:0]   count_sum;
   logic [DW-1:0] dict_next;
   logic [DW-1:0] depth_m1;

   // memories and their ports
   logic [7:0]    stack_mem [1 << CW];
   logic [7:0]    stack_q;
   logic          stack_we;
   logic [CW-1:0] stack_wa;
   logic [7:0]    stack_wd;
   logic          stack_re;
   lzwd_pkg::dict_wr_type dict_wr;
   logic          dict_re;
   logic [CW-1:0] dict_prefix;
   logic [7:0]    dict_data;

   logic          csr_write;

   lzwd_dict u_dict (
      .clock     (clock),
      .wr        (dict_wr),
      .rd_en     (dict_re),
      .rd_addr   (walk_c_ff),
      .rd_prefix (dict_prefix),
      .rd_data   (dict_data)
   );

   // register port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite &&
                       (csr_paddr == lzwd_pkg::ADDR_EXPECTED);
   assign csr_prdata = (csr_paddr == lzwd_pkg::ADDR_EXPECTED) ?
                       {{(32-NW){1'b0}}, expected_ff} : 32'd0;
   assign expected_in = csr_write ? csr_pwdata[NW-1:0] : expected_ff;

   // unpack a byte into the bit buffer
   assign merged    = bitbuf_ff | (BW'(req_tdata) << bitcnt_ff);
   assign cnt_sum   = bitcnt_ff + 5'd8;
   assign code_mask = 12'hFFF >> (4'd12 - width_ff);
   assign running   = (status_ff == lzwd_pkg::STAT_RUNNING) &&
                      (depth_ff == '0) && !repeat_ff;
   assign depth_m1  = depth_ff - 13'd1;

   // decode helpers
   assign special     = ({1'b0, code_ff} == dict_size_ff);
   assign chain_start = special ? prev_ff : code_ff;
   assign adding      = (prev_ff != lzwd_pkg::CODE_CLEAR);
   assign str_len     = NW'(wdepth_ff) + NW'(1) + NW'(special_ff);
   assign count_sum   = {1'b0, count_ff} + {1'b0, str_len};
   assign dict_next   = dict_size_ff + 13'd1;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lzwd_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               if (req_tuser == lzwd_pkg::KIND_BYTE && running &&
                   cnt_sum >= {1'b0, width_ff}) begin
                  state_in = lzwd_pkg::ST_DECODE;
               end else if (req_tuser == lzwd_pkg::KIND_PULL && depth_ff != '0) begin
                  state_in = lzwd_pkg::ST_POP;
               end else begin
                  state_in = lzwd_pkg::ST_RESP;
               end
            end
         end
         lzwd_pkg::ST_DECODE: begin
            if (phase_ff && code_ff != lzwd_pkg::CODE_STOP &&
                code_ff != lzwd_pkg::CODE_CLEAR &&
                {1'b0, code_ff} <= dict_size_ff &&
                chain_start != lzwd_pkg::CODE_CLEAR) begin
               state_in = lzwd_pkg::ST_WALK_RD;
            end else begin
               state_in = lzwd_pkg::ST_RESP;
            end
         end
         lzwd_pkg::ST_WALK_RD: begin
            if (walk_c_ff < lzwd_pkg::CODE_FIRST) begin
               state_in = lzwd_pkg::ST_FINISH;
            end else if (wdepth_ff >= lzwd_pkg::DICT_FULL) begin
               state_in = lzwd_pkg::ST_RESP;
            end else begin
               state_in = lzwd_pkg::ST_WALK_WR;
            end
         end
         lzwd_pkg::ST_WALK_WR: state_in = lzwd_pkg::ST_WALK_RD;
         lzwd_pkg::ST_FINISH:  state_in = lzwd_pkg::ST_RESP;
         lzwd_pkg::ST_POP:     state_in = lzwd_pkg::ST_RESP;
         lzwd_pkg::ST_RESP: begin
            if (rsp_tready) begin
               state_in = lzwd_pkg::ST_IDLE;
            end
         end
         default: state_in = lzwd_pkg::ST_IDLE;
      endcase
   end

   // handshake and read strobes
   always_comb begin
      req_tready = (state_ff == lzwd_pkg::ST_IDLE);
      rsp_tvalid = (state_ff == lzwd_pkg::ST_RESP);
      dict_re    = (state_ff == lzwd_pkg::ST_WALK_RD);
      stack_re   = (state_ff == lzwd_pkg::ST_IDLE) && req_tvalid &&
                   (req_tuser == lzwd_pkg::KIND_PULL) && (depth_ff != '0);
   end

   // datapath
   always_comb begin
      bitbuf_in    = bitbuf_ff;
      bitcnt_in    = bitcnt_ff;
      width_in     = width_ff;
      dict_size_in = dict_size_ff;
      prev_in      = prev_ff;
      first_in     = first_ff;
      count_in     = count_ff;
      repeat_in    = repeat_ff;
      phase_in     = phase_ff;
      status_in    = status_ff;
      depth_in     = depth_ff;
      code_in      = code_ff;
      walk_c_in    = walk_c_ff;
      wdepth_in    = wdepth_ff;
      special_in   = special_ff;
      acc_in       = acc_ff;
      valid_in     = valid_ff;
      obyte_in     = obyte_ff;
      stack_we     = 1'b0;
      stack_wa     = wdepth_ff[CW-1:0];
      stack_wd     = dict_data;
      dict_wr      = '{en: 1'b0, addr: dict_size_ff[CW-1:0], prefix: prev_ff,
                       data: walk_c_ff[7:0]};

      case (state_ff)
         lzwd_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               acc_in   = 1'b0;
               valid_in = 1'b0;
               obyte_in = 8'd0;
               case (req_tuser)
                  lzwd_pkg::KIND_START: begin
                     bitbuf_in    = '0;
                     bitcnt_in    = '0;
                     width_in     = lzwd_pkg::START_WIDTH;
                     dict_size_in = lzwd_pkg::DICT_FIRST;
                     prev_in      = lzwd_pkg::CODE_CLEAR;
                     first_in     = 8'd0;
                     count_in     = '0;
                     repeat_in    = 1'b0;
                     phase_in     = 1'b0;
                     status_in    = lzwd_pkg::STAT_RUNNING;
                     depth_in     = '0;
                  end
                  lzwd_pkg::KIND_BYTE: begin
                     if (running) begin
                        acc_in = 1'b1;
                        if (cnt_sum >= {1'b0, width_ff}) begin
                           code_in   = merged[CW-1:0] & code_mask;
                           bitbuf_in = merged >> width_ff;
                           bitcnt_in = cnt_sum - {1'b0, width_ff};
                        end else begin
                           bitbuf_in = merged;
                           bitcnt_in = cnt_sum;
                        end
                     end
                  end
                  lzwd_pkg::KIND_END: begin
                     if (status_ff == lzwd_pkg::STAT_RUNNING) begin
                        status_in = lzwd_pkg::STAT_TRUNCATED;
                        depth_in  = '0;
                        repeat_in = 1'b0;
                     end
                  end
                  lzwd_pkg::KIND_PULL: begin
                     if (depth_ff != '0) begin
                        depth_in = depth_m1;
                     end else if (repeat_ff) begin
                        repeat_in = 1'b0;
                        valid_in  = 1'b1;
                        obyte_in  = first_ff;
                     end
                  end
                  default: ;
               endcase
            end
         end

         lzwd_pkg::ST_DECODE: begin
            if (!phase_ff) begin
               // first code must be a clear that opens the stream, or a stop
               if (code_ff == lzwd_pkg::CODE_STOP) begin
                  status_in = (expected_ff == '0) ? lzwd_pkg::STAT_DONE
                                                  : lzwd_pkg::STAT_MISMATCH;
               end else if (code_ff == lzwd_pkg::CODE_CLEAR) begin
                  phase_in = 1'b1;
               end else begin
                  status_in = lzwd_pkg::STAT_BAD_CODE;
               end
            end else if (code_ff == lzwd_pkg::CODE_STOP) begin
               status_in = (count_ff == expected_ff) ? lzwd_pkg::STAT_DONE
                                                     : lzwd_pkg::STAT_MISMATCH;
            end else if (code_ff == lzwd_pkg::CODE_CLEAR) begin
               width_in     = lzwd_pkg::START_WIDTH;
               dict_size_in = lzwd_pkg::DICT_FIRST;
               prev_in      = lzwd_pkg::CODE_CLEAR;
            end else if ({1'b0, code_ff} > dict_size_ff ||
                         chain_start == lzwd_pkg::CODE_CLEAR) begin
               status_in = lzwd_pkg::STAT_BAD_CODE;
            end else begin
               walk_c_in  = chain_start;
               wdepth_in  = '0;
               special_in = special;
            end
         end

         lzwd_pkg::ST_WALK_RD: begin
            if (walk_c_ff >= lzwd_pkg::CODE_FIRST && wdepth_ff >= lzwd_pkg::DICT_FULL) begin
               status_in = lzwd_pkg::STAT_BAD_CODE;
            end
         end

         lzwd_pkg::ST_WALK_WR: begin
            // push the suffix and follow the prefix link
            stack_we  = 1'b1;
            stack_wd  = dict_data;
            wdepth_in = wdepth_ff + 13'd1;
            walk_c_in = dict_prefix;
         end

         lzwd_pkg::ST_FINISH: begin
            if (walk_c_ff[CW-1:8] != '0 || wdepth_ff >= lzwd_pkg::DICT_FULL) begin
               status_in = lzwd_pkg::STAT_BAD_CODE;
            end else if ((adding && dict_size_ff >= lzwd_pkg::DICT_FULL) ||
                         count_sum > {1'b0, expected_ff}) begin
               status_in = lzwd_pkg::STAT_OVERFLOW;
            end else begin
               stack_we = 1'b1;
               stack_wd = walk_c_ff[7:0];
               depth_in = wdepth_ff + 13'd1;
               first_in = walk_c_ff[7:0];
               count_in = count_sum[NW-1:0];
               if (adding) begin
                  dict_wr.en   = 1'b1;
                  dict_size_in = dict_next;
                  repeat_in    = special_ff;
                  if (dict_next == (13'd1 << width_ff) && width_ff < lzwd_pkg::MAX_WIDTH) begin
                     width_in = width_ff + 4'd1;
                  end
               end
               prev_in = code_ff;
            end
         end

         lzwd_pkg::ST_POP: begin
            valid_in = 1'b1;
            obyte_in = stack_q;
         end

         default: ;
      endcase
   end

   // reverse stack memory
   always_ff @(posedge clock) begin
      if (stack_we) begin
         stack_mem[stack_wa] <= stack_wd;
      end
      if (stack_re) begin
         stack_q <= stack_mem[depth_m1[CW-1:0]];
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lzwd_pkg::ST_IDLE;
         bitbuf_ff    <= '0;
         bitcnt_ff    <= '0;
         width_ff     <= lzwd_pkg::START_WIDTH;
         dict_size_ff <= lzwd_pkg::DICT_FIRST;
         prev_ff      <= lzwd_pkg::CODE_CLEAR;
         first_ff     <= 8'd0;
         count_ff     <= '0;
         repeat_ff    <= 1'b0;
         phase_ff     <= 1'b0;
         status_ff    <= lzwd_pkg::STAT_RUNNING;
         depth_ff     <= '0;
         expected_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         bitbuf_ff    <= bitbuf_in;
         bitcnt_ff    <= bitcnt_in;
         width_ff     <= width_in;
         dict_size_ff <= dict_size_in;
         prev_ff      <= prev_in;
         first_ff     <= first_in;
         count_ff     <= count_in;
         repeat_ff    <= repeat_in;
         phase_ff     <= phase_in;
         status_ff    <= status_in;
         depth_ff     <= depth_in;
         expected_ff  <= expected_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      code_ff    <= code_in;
      walk_c_ff  <= walk_c_in;
      wdepth_ff  <= wdepth_in;
      special_ff <= special_in;
      acc_ff     <= acc_in;
      valid_ff   <= valid_in;
      obyte_ff   <= obyte_in;
   end

   // response word
   assign rsp_tdata = {4'd0, count_ff, status_ff, obyte_ff};
   assign rsp_tuser = {running, valid_ff, acc_ff};

`ifndef SYNTHESIS
   a_walk_depth: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lzwd_pkg::ST_WALK_WR) |-> (wdepth_ff < lzwd_pkg::DICT_FULL))
      else $error("walk depth passed the stack size");

   a_stop_flush: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lzwd_pkg::ST_RESP && status_ff != lzwd_pkg::STAT_RUNNING) |->
      (depth_ff == '0 && !repeat_ff))
      else $error("output pending after the stream stopped");

   a_width_range: assert property (@(posedge clock) disable iff (reset)
      (width_ff >= lzwd_pkg::START_WIDTH && width_ff <= lzwd_pkg::MAX_WIDTH))
      else $error("code width out of range");

   a_pop_source: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lzwd_pkg::ST_POP) |-> $past(req_tvalid && req_tready))
      else $error("stack pop without a pull word");
`endif

endmodule

`default_nettype wire
